// ===== rtl/core/pfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsa_pkg
// Types, sizes and reset-content helpers for the page frame stack allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  // Sizing
  localparam int STACK_DEPTH     = 2048;
  localparam int MAPPED_TABLES   = 3;
  localparam int KERNEL_PAGES    = 1024;

  localparam int ADDR_W          = 32;
  localparam int TABLE_W         = 10;
  localparam int ENTRY_W         = 10;
  localparam int TABLE_SHIFT     = 22;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGES_PER_TABLE = 1024;

  localparam int STACK_IDX_W     = $clog2(STACK_DEPTH);
  localparam int SP_W            = $clog2(STACK_DEPTH + 1);

  // Present map is stored as rows of 32 bits
  localparam int PRESENT_BITS    = MAPPED_TABLES * PAGES_PER_TABLE;
  localparam int PRESENT_IDX_W   = $clog2(PRESENT_BITS);
  localparam int ROW_BITS        = 32;
  localparam int ROW_SEL_W       = 5;
  localparam int PRESENT_ROWS    = PRESENT_BITS / ROW_BITS;
  localparam int ROW_IDX_W       = PRESENT_IDX_W - ROW_SEL_W;

  // Start-up fill sweep
  localparam int STACK_INIT_COUNT = STACK_DEPTH - KERNEL_PAGES;
  localparam int INIT_LEN   = (STACK_INIT_COUNT > PRESENT_ROWS) ? STACK_INIT_COUNT
                                                                : PRESENT_ROWS;
  localparam int INIT_CNT_W = $clog2(INIT_LEN + 1);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_ENABLE  = 2'd2,
    ACT_DISABLE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_UNMAPPED = 3'd2,
    ST_WRONG    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_POP,
    S_RMW
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   page_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    status_t             status;
  } resp_t;

  // Table field lies inside the mapped range
  function automatic logic is_mapped(input logic [ADDR_W-1:0] addr);
    logic [TABLE_W:0] table_num;
    table_num = {1'b0, addr[TABLE_SHIFT +: TABLE_W]};
    return table_num < (TABLE_W + 1)'(MAPPED_TABLES);
  endfunction

  // Flat page index: table * 1024 + entry
  function automatic logic [PRESENT_IDX_W-1:0] page_index(input logic [ADDR_W-1:0] addr);
    logic [TABLE_W+ENTRY_W-1:0] full_idx;
    full_idx = {addr[TABLE_SHIFT +: TABLE_W], addr[PAGE_SHIFT +: ENTRY_W]};
    return full_idx[PRESENT_IDX_W-1:0];
  endfunction

  // Reset content of one present row: kernel pages set
  function automatic logic [ROW_BITS-1:0] init_row(input int row);
    logic [ROW_BITS-1:0] bits;
    for (int b = 0; b < ROW_BITS; b++) begin
      bits[b] = (row * ROW_BITS + b) < KERNEL_PAGES;
    end
    return bits;
  endfunction

  // Reset content of one stack slot: highest frame at the bottom
  function automatic logic [ADDR_W-1:0] init_frame(input int slot);
    logic [63:0] frame;
    frame = 64'(STACK_DEPTH - 1 - slot) << PAGE_SHIFT;
    return frame[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/page_frame_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_stack_allocator
// LIFO allocator of free 4 KiB frames with a present bit per mapped page.
//
// After reset the block runs a fill sweep that loads the free stack and the
// present map, and accepts no transaction until it ends. A free, enable or
// disable reads a present row and then finishes in the read-modify-write
// step; an allocate that pops an entry reads the stack first and then does
// the present-map read-modify-write, or drops the popped frame when it lies
// in an unmapped table. A request is rejected at once when it needs no memory
// access (empty stack, unmapped table). Each transaction returns exactly one
// response; the response register lets the next request be taken while the
// previous response is leaving. Both stores are single-write, registered-read
// memories; the present map is held as 32-bit rows.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator
  import pfsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  resp_valid,
  input  logic  resp_ready,
  output resp_t resp
);

  // Memories
  logic [ADDR_W-1:0]   stack_mem [STACK_DEPTH];
  logic [ROW_BITS-1:0] present_mem [PRESENT_ROWS];

  logic                   stack_rd_en, stack_wr_en;
  logic [STACK_IDX_W-1:0] stack_rd_addr, stack_wr_addr;
  logic [ADDR_W-1:0]      stack_wr_data, stack_rdata;

  logic                   pres_rd_en, pres_wr_en;
  logic [ROW_IDX_W-1:0]   pres_rd_addr, pres_wr_addr;
  logic [ROW_BITS-1:0]    pres_wr_data, pres_rdata;

  // Control registers
  state_t                 state, state_next;
  logic [SP_W-1:0]        sp, sp_next;
  logic [INIT_CNT_W-1:0]  init_cnt, init_cnt_next;
  action_t                act, act_next;
  logic [ADDR_W-1:0]      work, work_next;

  logic                   load_out;
  resp_t                  resp_next;

  logic [SP_W-1:0]          sp_m1;
  logic [PRESENT_IDX_W-1:0] req_idx, pop_idx, work_idx;
  logic                     cur_bit;
  logic [ROW_BITS-1:0]      row_mod;

  assign sp_m1    = sp - 1'b1;
  assign req_idx  = page_index(req.page_address);
  assign pop_idx  = page_index(stack_rdata);
  assign work_idx = page_index(work);
  assign cur_bit  = pres_rdata[work_idx[ROW_SEL_W-1:0]];

  // Free stack memory
  always_ff @(posedge clk) begin
    if (stack_wr_en) begin
      stack_mem[stack_wr_addr] <= stack_wr_data;
    end
    if (stack_rd_en) begin
      stack_rdata <= stack_mem[stack_rd_addr];
    end
  end

  // Present map memory
  always_ff @(posedge clk) begin
    if (pres_wr_en) begin
      present_mem[pres_wr_addr] <= pres_wr_data;
    end
    if (pres_rd_en) begin
      pres_rdata <= present_mem[pres_rd_addr];
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sp       <= SP_W'(STACK_INIT_COUNT);
      init_cnt <= '0;
      act      <= ACT_ALLOC;
    end else begin
      state    <= state_next;
      sp       <= sp_next;
      init_cnt <= init_cnt_next;
      act      <= act_next;
    end
  end

  // Working address needs no reset
  always_ff @(posedge clk) begin
    work <= work_next;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (load_out) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      resp <= resp_next;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next    = state;
    sp_next       = sp;
    init_cnt_next = init_cnt;
    act_next      = act;
    work_next     = work;
    req_ready     = 1'b0;
    load_out      = 1'b0;
    resp_next     = '{granted_address: '0, status: ST_OK};

    stack_rd_en   = 1'b0;
    stack_rd_addr = sp_m1[STACK_IDX_W-1:0];
    stack_wr_en   = 1'b0;
    stack_wr_addr = sp[STACK_IDX_W-1:0];
    stack_wr_data = work;

    pres_rd_en    = 1'b0;
    pres_rd_addr  = req_idx[PRESENT_IDX_W-1:ROW_SEL_W];
    pres_wr_en    = 1'b0;
    pres_wr_addr  = work_idx[PRESENT_IDX_W-1:ROW_SEL_W];
    row_mod       = pres_rdata;
    pres_wr_data  = row_mod;

    case (state)
      // Load reset contents, one slot and one row per cycle
      S_INIT: begin
        stack_wr_addr = init_cnt[STACK_IDX_W-1:0];
        stack_wr_data = init_frame(int'(init_cnt));
        stack_wr_en   = init_cnt < INIT_CNT_W'(STACK_INIT_COUNT);
        pres_wr_addr  = init_cnt[ROW_IDX_W-1:0];
        pres_wr_data  = init_row(int'(init_cnt));
        pres_wr_en    = init_cnt < INIT_CNT_W'(PRESENT_ROWS);
        init_cnt_next = init_cnt + 1'b1;
        if (init_cnt == INIT_CNT_W'(INIT_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end

      // Take a request; reject at once where no memory access is needed
      S_IDLE: begin
        req_ready = !resp_valid || resp_ready;
        if (req_valid && req_ready) begin
          act_next  = req.action;
          work_next = req.page_address;
          if (req.action == ACT_ALLOC) begin
            if (sp == '0) begin
              load_out         = 1'b1;
              resp_next.status = ST_EMPTY;
            end else begin
              stack_rd_en = 1'b1;
              sp_next     = sp_m1;
              state_next  = S_POP;
            end
          end else if (!is_mapped(req.page_address)) begin
            load_out         = 1'b1;
            resp_next.status = ST_UNMAPPED;
          end else begin
            pres_rd_en = 1'b1;
            state_next = S_RMW;
          end
        end
      end

      // Popped frame is back; drop it if its table is unmapped
      S_POP: begin
        work_next = stack_rdata;
        if (!is_mapped(stack_rdata)) begin
          load_out         = 1'b1;
          resp_next.status = ST_UNMAPPED;
          state_next       = S_IDLE;
        end else begin
          pres_rd_en   = 1'b1;
          pres_rd_addr = pop_idx[PRESENT_IDX_W-1:ROW_SEL_W];
          state_next   = S_RMW;
        end
      end

      // Present row is back: update it where the request is accepted and finish the transaction
      S_RMW: begin
        load_out   = 1'b1;
        state_next = S_IDLE;
        case (act)
          ACT_ALLOC: begin
            if (cur_bit) begin
              resp_next.status = ST_WRONG;
            end else begin
              row_mod[work_idx[ROW_SEL_W-1:0]] = 1'b1;
              pres_wr_en                = 1'b1;
              resp_next.granted_address = work;
            end
          end
          ACT_FREE: begin
            if (!cur_bit) begin
              resp_next.status = ST_WRONG;
            end else if (sp == SP_W'(STACK_DEPTH)) begin
              resp_next.status = ST_FULL;
            end else begin
              row_mod[work_idx[ROW_SEL_W-1:0]] = 1'b0;
              pres_wr_en  = 1'b1;
              stack_wr_en = 1'b1;
              sp_next     = sp + 1'b1;
            end
          end
          ACT_ENABLE: begin
            row_mod[work_idx[ROW_SEL_W-1:0]] = 1'b1;
            pres_wr_en = 1'b1;
          end
          default: begin
            row_mod[work_idx[ROW_SEL_W-1:0]] = 1'b0;
            pres_wr_en = 1'b1;
          end
        endcase
        pres_wr_data = row_mod;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
